@@ design/assert_macros.svh @@
// Assertion macros shared by the console writer modules.
// Each macro expects i_clk and i_rst_n to exist in the module that uses it.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The expression must hold at every clock edge out of reset.
`define ASSERT_ALWAYS(label, expr, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) \
        else $error(msg);

// The expression must never hold at a clock edge out of reset.
`define ASSERT_NEVER(label, expr, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(expr)) \
        else $error(msg);

// When the antecedent holds, the consequent must hold in the next cycle.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ design/tcw_pkg.sv @@
// Shared types, constants and helpers for the text console writer.
// Used by the front end, command queue, back end and top level.
package tcw_pkg;

    localparam int SCREEN_COLUMNS = 80;
    localparam int SCREEN_ROWS    = 25;
    localparam int CELL_COUNT     = SCREEN_COLUMNS * SCREEN_ROWS;

    localparam int COL_W  = 7;
    localparam int ROW_W  = 5;
    localparam int ADDR_W = $clog2(CELL_COUNT);
    localparam int CELL_W = 16;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [COL_W-1:0]  LAST_COL   = COL_W'(SCREEN_COLUMNS - 1);
    localparam logic [ROW_W-1:0]  LAST_ROW   = ROW_W'(SCREEN_ROWS - 1);
    localparam logic [ROW_W:0]    ROWS_WIDE  = (ROW_W + 1)'(SCREEN_ROWS);
    localparam logic [ADDR_W-1:0] LAST_ADDR  = ADDR_W'(CELL_COUNT - 1);
    localparam logic [ADDR_W-1:0] COLS_ADDR  = ADDR_W'(SCREEN_COLUMNS);

    localparam logic [7:0] RESET_ATTR   = 8'd7;
    localparam logic [7:0] SPACE_CHAR   = 8'd32;
    localparam logic [7:0] NEWLINE_CHAR = 8'd10;
    localparam logic [7:0] RETURN_CHAR  = 8'd13;
    localparam logic [7:0] PRINT_LOW    = 8'd32;
    localparam logic [7:0] PRINT_HIGH   = 8'd126;

    localparam logic [1:0] FUNC_PUT    = 2'd0;
    localparam logic [1:0] FUNC_CLEAR  = 2'd1;
    localparam logic [1:0] FUNC_SETCUR = 2'd2;
    localparam logic [1:0] FUNC_READ   = 2'd3;

    typedef enum logic [2:0] {
        OP_NOP,
        OP_NEWLINE,
        OP_RETURN,
        OP_PRINT,
        OP_CLEAR,
        OP_SETCUR,
        OP_READ
    } t_op;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_EXEC,
        ST_FILL,
        ST_CLEAR,
        ST_RDATA
    } t_state;

    typedef struct packed {
        t_op              op;
        logic [7:0]       ch;
        logic [7:0]       attr;
        logic [COL_W-1:0] col;
        logic [ROW_W-1:0] row;
    } t_cmd;

    typedef struct packed {
        logic valid;
        t_cmd cmd;
    } t_push;

    typedef struct packed {
        logic init_busy;
    } t_back_status;

    typedef struct packed {
        logic       en;
        logic [7:0] data;
    } t_cfg_wr;

    typedef struct packed {
        logic [COL_W-1:0] col;
        logic [ROW_W-1:0] row;
        logic [7:0]       ch;
        logic [7:0]       attr;
        logic             scrolled;
    } t_result;

    // Linear cell address of a physical row and a column.
    function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] prow,
                                                    input logic [COL_W-1:0] col);
        return ADDR_W'(prow) * COLS_ADDR + ADDR_W'(col);
    endfunction

    // The screen is a ring of rows: logical row r lives in physical row
    // (r + top) modulo the row count, so a scroll only moves the top.
    function automatic logic [ROW_W-1:0] phys_row(input logic [ROW_W-1:0] row,
                                                  input logic [ROW_W-1:0] top);
        logic [ROW_W:0] sum;
        sum = {1'b0, row} + {1'b0, top};
        if (sum >= ROWS_WIDE) begin
            sum = sum - ROWS_WIDE;
        end
        return sum[ROW_W-1:0];
    endfunction

endpackage

@@ design/text_console_writer.sv @@
// Top level of the text console writer: front end, command queue, back end.
// Depends on tcw_pkg, tcw_front, tcw_queue and tcw_back.
//
// An 80x25 text screen of character/attribute cells with a cursor. Requests
// go through a two-entry command queue to a back end that owns one
// single-port-write cell RAM. Put, carriage return, set cursor and ignored
// bytes are popped from the queue and then executed; a cell read also waits
// for the registered RAM read. A newline or a wrap on the last row
// recycles the top row as the new last row and fills it one cell per cycle.
// Clear rewrites all 2000 cells, one per cycle. After reset a clearing pass
// over all 2000 cells runs while o_in_stall is held high. A finished result
// waits in an output register, so the next request is accepted while it is
// held; the configuration register default_attr takes effect at the next
// clear.
module text_console_writer (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_wr_en,
    input  logic [7:0]                i_cfg_wr_data,
    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  logic [1:0]                i_func,
    input  logic [7:0]                i_ch,
    input  logic [7:0]                i_attr,
    input  logic [tcw_pkg::COL_W-1:0] i_column,
    input  logic [tcw_pkg::ROW_W-1:0] i_row,
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output logic [tcw_pkg::COL_W-1:0] o_cursor_column,
    output logic [tcw_pkg::ROW_W-1:0] o_cursor_row,
    output logic [7:0]                o_cell_char,
    output logic [7:0]                o_cell_attr,
    output logic                      o_scrolled
);

    tcw_pkg::t_push        push;
    tcw_pkg::t_back_status status;
    tcw_pkg::t_cfg_wr      cfg;
    tcw_pkg::t_cmd         q_cmd;
    tcw_pkg::t_result      result;
    logic                  q_valid;
    logic                  q_full;
    logic                  pop;

    assign cfg.en   = i_cfg_wr_en;
    assign cfg.data = i_cfg_wr_data;

    tcw_front u_front (
        .i_in_valid (i_in_valid),
        .i_func     (i_func),
        .i_ch       (i_ch),
        .i_attr     (i_attr),
        .i_column   (i_column),
        .i_row      (i_row),
        .i_q_full   (q_full),
        .i_status   (status),
        .o_in_stall (o_in_stall),
        .o_push     (push)
    );

    tcw_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_cmd   (q_cmd),
        .o_full  (q_full)
    );

    tcw_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_q_valid   (q_valid),
        .i_q_cmd     (q_cmd),
        .o_pop       (pop),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_result    (result),
        .o_status    (status)
    );

    assign o_cursor_column = result.col;
    assign o_cursor_row    = result.row;
    assign o_cell_char     = result.ch;
    assign o_cell_attr     = result.attr;
    assign o_scrolled      = result.scrolled;

endmodule

@@ design/tcw_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing; holds the screen cells.
module tcw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ design/tcw_front.sv @@
// Front end: takes input requests and decodes them into queue commands.
// Depends on tcw_pkg.
module tcw_front (
    input  logic                       i_in_valid,
    input  logic [1:0]                 i_func,
    input  logic [7:0]                 i_ch,
    input  logic [7:0]                 i_attr,
    input  logic [tcw_pkg::COL_W-1:0]  i_column,
    input  logic [tcw_pkg::ROW_W-1:0]  i_row,
    input  logic                       i_q_full,
    input  tcw_pkg::t_back_status      i_status,
    output logic                       o_in_stall,
    output tcw_pkg::t_push             o_push
);

    tcw_pkg::t_op op;
    logic         printable;

    assign printable = (i_ch >= tcw_pkg::PRINT_LOW) && (i_ch <= tcw_pkg::PRINT_HIGH);

    always_comb begin
        case (i_func)
            tcw_pkg::FUNC_PUT: begin
                if (i_ch == tcw_pkg::NEWLINE_CHAR) begin
                    op = tcw_pkg::OP_NEWLINE;
                end else if (i_ch == tcw_pkg::RETURN_CHAR) begin
                    op = tcw_pkg::OP_RETURN;
                end else if (printable) begin
                    op = tcw_pkg::OP_PRINT;
                end else begin
                    op = tcw_pkg::OP_NOP;
                end
            end
            tcw_pkg::FUNC_CLEAR:  op = tcw_pkg::OP_CLEAR;
            tcw_pkg::FUNC_SETCUR: op = tcw_pkg::OP_SETCUR;
            tcw_pkg::FUNC_READ:   op = tcw_pkg::OP_READ;
            default:              op = tcw_pkg::OP_NOP;
        endcase
    end

    // Nothing is taken while the back end sweeps the store after reset.
    assign o_in_stall = i_q_full || i_status.init_busy;

    always_comb begin
        o_push.valid    = i_in_valid && !o_in_stall;
        o_push.cmd.op   = op;
        o_push.cmd.ch   = i_ch;
        o_push.cmd.attr = i_attr;
        o_push.cmd.col  = (i_column > tcw_pkg::LAST_COL) ? tcw_pkg::LAST_COL : i_column;
        o_push.cmd.row  = (i_row > tcw_pkg::LAST_ROW) ? tcw_pkg::LAST_ROW : i_row;
    end

endmodule

@@ design/tcw_queue.sv @@
// Short command queue between the front end and the back end.
// Depends on tcw_pkg and assert_macros.svh.
`include "assert_macros.svh"

module tcw_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  tcw_pkg::t_push i_push,
    input  logic           i_pop,
    output logic           o_valid,
    output tcw_pkg::t_cmd  o_cmd,
    output logic           o_full
);

    tcw_pkg::t_cmd                 r_slot [tcw_pkg::QUEUE_DEPTH];
    logic [tcw_pkg::QPTR_W-1:0]    r_wr_ptr, n_wr_ptr;
    logic [tcw_pkg::QPTR_W-1:0]    r_rd_ptr, n_rd_ptr;
    logic [tcw_pkg::QCNT_W-1:0]    r_count,  n_count;

    localparam logic [tcw_pkg::QPTR_W-1:0] LAST_PTR = tcw_pkg::QPTR_W'(tcw_pkg::QUEUE_DEPTH - 1);
    localparam logic [tcw_pkg::QCNT_W-1:0] FULL_CNT = tcw_pkg::QCNT_W'(tcw_pkg::QUEUE_DEPTH);

    assign o_valid = (r_count != '0);
    assign o_full  = (r_count == FULL_CNT);
    assign o_cmd   = r_slot[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push.valid) begin
            n_wr_ptr = (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + tcw_pkg::QPTR_W'(1);
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + tcw_pkg::QPTR_W'(1);
        end
        if (i_push.valid && !i_pop) begin
            n_count = r_count + tcw_pkg::QCNT_W'(1);
        end else if (!i_push.valid && i_pop) begin
            n_count = r_count - tcw_pkg::QCNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.valid) begin
            r_slot[r_wr_ptr] <= i_push.cmd;
        end
    end

    `ASSERT_NEVER(a_push_when_full, i_push.valid && o_full, "command pushed into a full queue")
    `ASSERT_NEVER(a_pop_when_empty, i_pop && !o_valid, "command popped from an empty queue")

endmodule

@@ design/tcw_back.sv @@
// Back end: executes queued commands on the cell RAM and the cursor, and
// holds the result register. Depends on tcw_pkg, tcw_ram and assert_macros.svh.
`include "assert_macros.svh"

module tcw_back (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  tcw_pkg::t_cfg_wr      i_cfg,
    input  logic                  i_q_valid,
    input  tcw_pkg::t_cmd         i_q_cmd,
    output logic                  o_pop,
    input  logic                  i_out_stall,
    output logic                  o_out_valid,
    output tcw_pkg::t_result      o_result,
    output tcw_pkg::t_back_status o_status
);

    tcw_pkg::t_state                r_state, n_state;
    tcw_pkg::t_cmd                  r_cmd, n_cmd;
    logic [tcw_pkg::COL_W-1:0]      r_col, n_col;
    logic [tcw_pkg::ROW_W-1:0]      r_row, n_row;
    logic [tcw_pkg::ROW_W-1:0]      r_top, n_top;
    logic [7:0]                     r_fill_attr, n_fill_attr;
    logic [7:0]                     r_default_attr, n_default_attr;
    logic [tcw_pkg::ADDR_W-1:0]     r_addr, n_addr;
    logic [tcw_pkg::COL_W-1:0]      r_cnt, n_cnt;
    logic                           r_out_valid, n_out_valid;
    tcw_pkg::t_result               r_out, n_out;

    logic                           out_free;
    logic                           scroll_now;
    logic                           finish;
    logic                           scr;
    logic [7:0]                     rd_ch;
    logic [7:0]                     rd_attr;
    logic [tcw_pkg::COL_W-1:0]      sel_col;
    logic [tcw_pkg::ROW_W-1:0]      sel_row;
    logic [tcw_pkg::ADDR_W-1:0]     cur_addr;
    logic [tcw_pkg::ADDR_W-1:0]     top_addr;
    logic                           ram_we;
    logic [tcw_pkg::ADDR_W-1:0]     ram_waddr;
    logic [tcw_pkg::CELL_W-1:0]     ram_wdata;
    logic [tcw_pkg::CELL_W-1:0]     ram_rdata;

    assign out_free = !r_out_valid || !i_out_stall;

    // A read addresses the requested cell; everything else the cursor cell.
    assign sel_col  = (r_cmd.op == tcw_pkg::OP_READ) ? r_cmd.col : r_col;
    assign sel_row  = (r_cmd.op == tcw_pkg::OP_READ) ? r_cmd.row : r_row;
    assign cur_addr = tcw_pkg::cell_addr(tcw_pkg::phys_row(sel_row, r_top), sel_col);

    // On a scroll the physical row at the top becomes the new last row.
    assign top_addr = tcw_pkg::cell_addr(r_top, '0);

    assign scroll_now = (r_row == tcw_pkg::LAST_ROW) &&
                        ((r_cmd.op == tcw_pkg::OP_NEWLINE) ||
                         ((r_cmd.op == tcw_pkg::OP_PRINT) && (r_col == tcw_pkg::LAST_COL)));

    tcw_ram #(
        .WIDTH (tcw_pkg::CELL_W),
        .DEPTH (tcw_pkg::CELL_COUNT)
    ) u_cells (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (cur_addr),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            tcw_pkg::ST_INIT: begin
                if (r_addr == tcw_pkg::LAST_ADDR) begin
                    n_state = tcw_pkg::ST_IDLE;
                end
            end
            tcw_pkg::ST_IDLE: begin
                if (i_q_valid && out_free) begin
                    n_state = tcw_pkg::ST_EXEC;
                end
            end
            tcw_pkg::ST_EXEC: begin
                if (r_cmd.op == tcw_pkg::OP_CLEAR) begin
                    n_state = tcw_pkg::ST_CLEAR;
                end else if (r_cmd.op == tcw_pkg::OP_READ) begin
                    n_state = tcw_pkg::ST_RDATA;
                end else if (scroll_now) begin
                    n_state = tcw_pkg::ST_FILL;
                end else begin
                    n_state = tcw_pkg::ST_IDLE;
                end
            end
            tcw_pkg::ST_FILL: begin
                if (r_cnt == tcw_pkg::LAST_COL) begin
                    n_state = tcw_pkg::ST_IDLE;
                end
            end
            tcw_pkg::ST_CLEAR: begin
                if (r_addr == tcw_pkg::LAST_ADDR) begin
                    n_state = tcw_pkg::ST_IDLE;
                end
            end
            tcw_pkg::ST_RDATA: begin
                n_state = tcw_pkg::ST_IDLE;
            end
            default: begin
                n_state = tcw_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        n_cmd          = r_cmd;
        n_col          = r_col;
        n_row          = r_row;
        n_top          = r_top;
        n_fill_attr    = r_fill_attr;
        n_default_attr = i_cfg.en ? i_cfg.data : r_default_attr;
        n_addr         = r_addr;
        n_cnt          = r_cnt;
        n_out_valid    = r_out_valid && i_out_stall;
        n_out          = r_out;
        o_pop          = 1'b0;
        finish         = 1'b0;
        scr            = 1'b0;
        rd_ch          = '0;
        rd_attr        = '0;
        ram_we         = 1'b0;
        ram_waddr      = r_addr;
        ram_wdata      = {r_fill_attr, tcw_pkg::SPACE_CHAR};

        case (r_state)
            tcw_pkg::ST_INIT: begin
                ram_we    = 1'b1;
                ram_wdata = {tcw_pkg::RESET_ATTR, tcw_pkg::SPACE_CHAR};
                n_addr    = (r_addr == tcw_pkg::LAST_ADDR) ? '0
                                                           : r_addr + tcw_pkg::ADDR_W'(1);
            end
            tcw_pkg::ST_IDLE: begin
                if (i_q_valid && out_free) begin
                    o_pop = 1'b1;
                    n_cmd = i_q_cmd;
                end
            end
            tcw_pkg::ST_EXEC: begin
                case (r_cmd.op)
                    tcw_pkg::OP_NEWLINE: begin
                        n_col = '0;
                        if (!scroll_now) begin
                            n_row  = r_row + tcw_pkg::ROW_W'(1);
                            finish = 1'b1;
                        end
                    end
                    tcw_pkg::OP_RETURN: begin
                        n_col  = '0;
                        finish = 1'b1;
                    end
                    tcw_pkg::OP_PRINT: begin
                        n_fill_attr = r_cmd.attr;
                        ram_we      = 1'b1;
                        ram_waddr   = cur_addr;
                        ram_wdata   = {r_cmd.attr, r_cmd.ch};
                        if (r_col != tcw_pkg::LAST_COL) begin
                            n_col  = r_col + tcw_pkg::COL_W'(1);
                            finish = 1'b1;
                        end else begin
                            n_col = '0;
                            if (!scroll_now) begin
                                n_row  = r_row + tcw_pkg::ROW_W'(1);
                                finish = 1'b1;
                            end
                        end
                    end
                    tcw_pkg::OP_CLEAR: begin
                        n_fill_attr = r_default_attr;
                        n_col       = '0;
                        n_row       = '0;
                        n_top       = '0;
                        n_addr      = '0;
                    end
                    tcw_pkg::OP_SETCUR: begin
                        n_col  = r_cmd.col;
                        n_row  = r_cmd.row;
                        finish = 1'b1;
                    end
                    tcw_pkg::OP_READ: begin
                        // The RAM read is in flight; the data is taken next cycle.
                    end
                    default: begin
                        finish = 1'b1;
                    end
                endcase
                if (scroll_now) begin
                    n_addr = top_addr;
                    n_cnt  = '0;
                    n_top  = (r_top == tcw_pkg::LAST_ROW) ? '0 : r_top + tcw_pkg::ROW_W'(1);
                end
            end
            tcw_pkg::ST_FILL: begin
                ram_we = 1'b1;
                n_addr = r_addr + tcw_pkg::ADDR_W'(1);
                n_cnt  = r_cnt + tcw_pkg::COL_W'(1);
                if (r_cnt == tcw_pkg::LAST_COL) begin
                    finish = 1'b1;
                    scr    = 1'b1;
                end
            end
            tcw_pkg::ST_CLEAR: begin
                ram_we = 1'b1;
                if (r_addr == tcw_pkg::LAST_ADDR) begin
                    n_addr = '0;
                    finish = 1'b1;
                end else begin
                    n_addr = r_addr + tcw_pkg::ADDR_W'(1);
                end
            end
            tcw_pkg::ST_RDATA: begin
                finish  = 1'b1;
                rd_ch   = ram_rdata[7:0];
                rd_attr = ram_rdata[15:8];
            end
            default: begin
            end
        endcase

        // The result slot is known to be empty here: a command is popped
        // only when the slot is free or draining.
        if (finish) begin
            n_out_valid    = 1'b1;
            n_out.col      = n_col;
            n_out.row      = n_row;
            n_out.ch       = rd_ch;
            n_out.attr     = rd_attr;
            n_out.scrolled = scr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= tcw_pkg::ST_INIT;
            r_col          <= '0;
            r_row          <= '0;
            r_top          <= '0;
            r_fill_attr    <= tcw_pkg::RESET_ATTR;
            r_default_attr <= tcw_pkg::RESET_ATTR;
            r_addr         <= '0;
            r_out_valid    <= 1'b0;
        end else begin
            r_state        <= n_state;
            r_col          <= n_col;
            r_row          <= n_row;
            r_top          <= n_top;
            r_fill_attr    <= n_fill_attr;
            r_default_attr <= n_default_attr;
            r_addr         <= n_addr;
            r_out_valid    <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd <= n_cmd;
        r_cnt <= n_cnt;
        r_out <= n_out;
    end

    assign o_out_valid        = r_out_valid;
    assign o_result           = r_out;
    assign o_status.init_busy = (r_state == tcw_pkg::ST_INIT);

    `ASSERT_ALWAYS(a_cursor_in_range, (r_col <= tcw_pkg::LAST_COL) && (r_row <= tcw_pkg::LAST_ROW), "cursor left the screen")
    `ASSERT_ALWAYS(a_top_in_range, r_top <= tcw_pkg::LAST_ROW, "ring top row out of range")
    `ASSERT_NEXT(a_pop_frees_slot, o_pop, !r_out_valid, "command started while a result was still held")

endmodule
